// File: hdl/rrcl_pkg.sv
// shared constants and types for the round-robin channel lock unit
`default_nettype none

package rrcl_pkg;

  // built channel count default and result cap per request
  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned MAX_RESULTS  = 32;

  // field widths
  localparam int unsigned CC_W    = 6;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned GCH_W   = 5;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // register indexes (taken from the word-address bit of paddr)
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_VALID_MASK    = 1'b1;

  // command codes
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // lock bit update strobes from the sequencer
  typedef struct packed {
    logic set;
    logic clr;
  } lock_ctl_t;

endpackage

`default_nettype wire

// File: hdl/rrcl_if.sv
// request and response channel interfaces
`default_nettype none

interface rrcl_req_if import rrcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [LIMIT_W-1:0] grant_limit;
  logic [CHAN_W-1:0]  channel;

  modport source (output valid, command, grant_limit, channel, input ready);
  modport sink   (input valid, command, grant_limit, channel, output ready);
endinterface

interface rrcl_rsp_if import rrcl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [GCH_W-1:0] granted_channel;
  logic             last;

  modport source (output valid, granted, granted_channel, last, input ready);
  modport sink   (input valid, granted, granted_channel, last, output ready);
endinterface

`default_nettype wire

// File: hdl/round_robin_channel_lock_unit.sv
// top level of the round-robin channel lock unit
// flow: a lock attempt passes ST_SETUP, then probes channels in ST_SCAN, up to n of them (n the clipped
//   channel count); a failed attempt ends in ST_FLUSH, and the last beat goes to the output register
// throughput: one request at a time; a lock request repeats setup and scan for each of its g grants,
//   an unlock goes straight to ST_FLUSH; the single-channel probe over the lock bits sets the pace
// reset: rst_ni is asynchronous, clears all lock bits, the start pointer and both registers
`default_nettype none

module round_robin_channel_lock_unit import rrcl_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  rrcl_req_if.sink               req_i,
  rrcl_rsp_if.source             rsp_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CC_W-1:0]   cc;
  logic [MASK_W-1:0] mask;
  lock_ctl_t         lock_ctl;
  logic [IW-1:0]     set_idx;
  logic [IW-1:0]     clr_idx;
  logic [IW-1:0]     look_idx;
  logic              lock_free;

  // configuration registers
  rrcl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cc_o    (cc),
    .mask_o  (mask)
  );

  // lock bits
  rrcl_lock_file #(
    .CHANNELS (CHANNELS)
  ) u_lock_file (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lock_ctl),
    .set_idx_i  (set_idx),
    .clr_idx_i  (clr_idx),
    .look_idx_i (look_idx),
    .mask_i     (mask),
    .free_o     (lock_free)
  );

  // request sequencer
  rrcl_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cc_i        (cc),
    .lock_free_i (lock_free),
    .lock_ctl_o  (lock_ctl),
    .set_idx_o   (set_idx),
    .clr_idx_o   (clr_idx),
    .look_idx_o  (look_idx),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: hdl/rrcl_cfg.sv
// apb configuration registers: channel count and valid mask
`default_nettype none

module rrcl_cfg import rrcl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CC_W-1:0]   cc_o,
  output logic      [MASK_W-1:0] mask_o
);

  logic [CC_W-1:0]   cc_q;
  logic [MASK_W-1:0] mask_q;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      mask_q <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_CHANNEL_COUNT) begin
        cc_q <= pwdata[CC_W-1:0];
      end else begin
        mask_q <= pwdata[MASK_W-1:0];
      end
    end
  end

  // read mux
  assign prdata = (reg_sel == REG_VALID_MASK) ? mask_q : DATA_W'(cc_q);

  assign cc_o   = cc_q;
  assign mask_o = mask_q;

endmodule

`default_nettype wire

// File: hdl/rrcl_lock_file.sv
// lock bit per channel with set, clear and a free-channel lookup
`default_nettype none

module rrcl_lock_file import rrcl_pkg::*; #(
  parameter  int unsigned CHANNELS = CHANNELS_DEF,
  localparam int unsigned IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lock_ctl_t         ctl_i,
  input  wire logic [IW-1:0]     set_idx_i,
  input  wire logic [IW-1:0]     clr_idx_i,
  input  wire logic [IW-1:0]     look_idx_i,
  input  wire logic [MASK_W-1:0] mask_i,
  output logic                   free_o
);

  logic [CHANNELS-1:0] lock_q;
  logic [6:0]          look_x;
  logic                mask_bit;

  // lock bit updates, set and clear never collide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= '0;
    end else begin
      if (ctl_i.set) begin
        lock_q[set_idx_i] <= 1'b1;
      end
      if (ctl_i.clr) begin
        lock_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  // channels at 32 and above have no mask bit
  assign look_x   = 7'(look_idx_i);
  assign mask_bit = (look_x < 7'(MASK_W)) ? mask_i[look_x[4:0]] : 1'b0;
  assign free_o   = !lock_q[look_idx_i] && mask_bit;

endmodule

`default_nettype wire

// File: hdl/rrcl_seq.sv
// request sequencer: one-channel-per-cycle scan, grant holding and result register
`default_nettype none

module rrcl_seq import rrcl_pkg::*; #(
  parameter  int unsigned CHANNELS = CHANNELS_DEF,
  localparam int unsigned IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned NW       = $clog2(CHANNELS + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CC_W-1:0] cc_i,
  input  wire logic            lock_free_i,
  output lock_ctl_t            lock_ctl_o,
  output logic      [IW-1:0]   set_idx_o,
  output logic      [IW-1:0]   clr_idx_o,
  output logic      [IW-1:0]   look_idx_o,
  rrcl_req_if.sink             req_i,
  rrcl_rsp_if.source           rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_HIT   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CC_W-1:0]    ptr_q, ptr_d;
  logic [IW-1:0]      c_q, c_d;
  logic [NW-1:0]      i_q, i_d;
  logic [LIMIT_W-1:0] cnt_q, cnt_d;
  logic [LIMIT_W-1:0] lim_q, lim_d;
  logic [GCH_W-1:0]   hit_q, hit_d;
  logic               pend_q, pend_d;
  logic [GCH_W-1:0]   pend_ch_q, pend_ch_d;

  logic               rsp_valid_q;
  logic               rsp_granted_q;
  logic [GCH_W-1:0]   rsp_ch_q;
  logic               rsp_last_q;

  logic               push;
  logic               push_granted;
  logic [GCH_W-1:0]   push_ch;
  logic               push_last;

  logic [NW-1:0]      n;
  logic [CC_W-1:0]    ptr_fix;
  logic [6:0]         c_x;
  logic [6:0]         c_inc;
  logic [IW-1:0]      c_next;
  logic [LIMIT_W-1:0] lim_in;
  logic [LIMIT_W-1:0] cnt_inc;
  logic               out_free;
  logic               req_acc;
  logic               unlock_ok;

  // scan bounds: channel count clipped to the built channels
  assign n       = (7'(cc_i) > 7'(CHANNELS)) ? NW'(CHANNELS) : NW'(cc_i);
  assign ptr_fix = (7'(ptr_q) >= 7'(n)) ? '0 : ptr_q;
  assign c_x     = 7'(c_q);
  assign c_inc   = c_x + 7'd1;
  assign c_next  = (c_inc == 7'(n)) ? '0 : c_inc[IW-1:0];

  // request decode
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign lim_in      = (req_i.grant_limit > LIMIT_W'(MAX_RESULTS)) ?
                       LIMIT_W'(MAX_RESULTS) : req_i.grant_limit;
  assign unlock_ok   = (7'(req_i.channel) < 7'(CHANNELS));
  assign cnt_inc     = cnt_q + 1'b1;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // lock file hookup
  assign set_idx_o  = c_q;
  assign look_idx_o = c_q;
  assign clr_idx_o  = req_i.channel[IW-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    c_d          = c_q;
    i_d          = i_q;
    cnt_d        = cnt_q;
    lim_d        = lim_q;
    hit_d        = hit_q;
    pend_d       = pend_q;
    pend_ch_d    = pend_ch_q;
    lock_ctl_o   = '0;
    push         = 1'b0;
    push_granted = 1'b0;
    push_ch      = '0;
    push_last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          pend_d = 1'b0;
          if (req_i.command == CMD_UNLOCK) begin
            lock_ctl_o.clr = unlock_ok;
            state_d        = ST_FLUSH;
          end else begin
            lim_d   = lim_in;
            cnt_d   = '0;
            state_d = (lim_in == '0) ? ST_FLUSH : ST_SETUP;
          end
        end
      end
      // one attempt starts: pointer wraps to zero when past the count
      ST_SETUP: begin
        ptr_d   = ptr_fix;
        c_d     = ptr_fix[IW-1:0];
        i_d     = '0;
        state_d = ST_SCAN;
      end
      // check one channel per cycle
      ST_SCAN: begin
        if (i_q == n) begin
          ptr_d   = ptr_q + 1'b1;
          state_d = ST_FLUSH;
        end else if (lock_free_i) begin
          lock_ctl_o.set = 1'b1;
          hit_d          = c_x[GCH_W-1:0];
          ptr_d          = ptr_q + 1'b1;
          state_d        = ST_HIT;
        end else begin
          c_d = c_next;
          i_d = i_q + 1'b1;
        end
      end
      // a new grant releases the held one as not last
      ST_HIT: begin
        if (!pend_q || out_free) begin
          if (pend_q) begin
            push         = 1'b1;
            push_granted = 1'b1;
            push_ch      = pend_ch_q;
          end
          pend_d    = 1'b1;
          pend_ch_d = hit_q;
          cnt_d     = cnt_inc;
          state_d   = (cnt_inc == lim_q) ? ST_FLUSH : ST_SETUP;
        end
      end
      // final beat: held grant, failure or unlock acknowledge
      ST_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_granted = pend_q;
          push_ch      = pend_q ? pend_ch_q : '0;
          push_last    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      lim_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      pend_q  <= pend_d;
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    i_q       <= i_d;
    hit_q     <= hit_d;
    pend_ch_q <= pend_ch_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      rsp_granted_q <= push_granted;
      rsp_ch_q      <= push_ch;
      rsp_last_q    <= push_last;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.granted         = rsp_granted_q;
  assign rsp_o.granted_channel = rsp_ch_q;
  assign rsp_o.last            = rsp_last_q;

  // grant count never passes the request limit
  a_cnt_le_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lim_q)
    else $error("grant count above limit");

  // while scanning the probe stays inside the scanned range
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && i_q != n) |-> (c_x < 7'(n)))
    else $error("scan index out of range");

  // a beat that is not last always carries a grant
  a_notlast_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_last_q) |-> rsp_granted_q)
    else $error("non-final beat without grant");

  // a found channel is always handed on, never dropped
  a_hit_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && i_q != n && lock_free_i) |=> (state_q == ST_HIT))
    else $error("grant not taken");

endmodule

`default_nettype wire
